@@ design/rfag_pkg.sv @@
// ----------------------------------------------------------------------------
// rfag_pkg
// Shared types and constants for the rotated framebuffer address generator.
// ----------------------------------------------------------------------------
package rfag_pkg;

   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 96;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ORIENTATION     = 3'd0,
      REG_DEST_DEPTH_MODE = 3'd1,
      REG_SRC_DEPTH_MODE  = 3'd2,
      REG_GUEST_COLS      = 3'd3,
      REG_GUEST_ROWS      = 3'd4,
      REG_SRC_ROW_PITCH   = 3'd5,
      REG_DEST_LINE_BYTES = 3'd6,
      REG_SRC_BASE        = 3'd7
   } reg_index_type;

   // source depth codes
   localparam logic [2:0] SRC_1BPP  = 3'd0;
   localparam logic [2:0] SRC_2BPP  = 3'd1;
   localparam logic [2:0] SRC_4BPP  = 3'd2;
   localparam logic [2:0] SRC_8BPP  = 3'd3;
   localparam logic [2:0] SRC_15BPP = 3'd4;
   localparam logic [2:0] SRC_16BPP = 3'd5;
   localparam logic [2:0] SRC_24BPP = 3'd6;

   // destination depth codes
   localparam logic [2:0] DST_8BPP  = 3'd0;
   localparam logic [2:0] DST_15BPP = 3'd1;
   localparam logic [2:0] DST_16BPP = 3'd2;
   localparam logic [2:0] DST_24BPP = 3'd3;

   typedef logic signed [1:0]  coef_type;
   typedef logic signed [17:0] step_type;

   typedef struct packed {
      coef_type r0;
      coef_type r1;
      coef_type r2;
      coef_type r3;
   } rot_type;

   localparam rot_type ROT_TAB [8] = '{
      '{ 2'sd1,  2'sd0,  2'sd0,  2'sd1},
      '{ 2'sd0, -2'sd1,  2'sd1,  2'sd0},
      '{-2'sd1,  2'sd0,  2'sd0, -2'sd1},
      '{ 2'sd0,  2'sd1, -2'sd1,  2'sd0},
      '{ 2'sd1,  2'sd0,  2'sd0, -2'sd1},
      '{ 2'sd0,  2'sd1,  2'sd1,  2'sd0},
      '{-2'sd1,  2'sd0,  2'sd0,  2'sd1},
      '{ 2'sd0, -2'sd1, -2'sd1,  2'sd0}
   };

   // values derived from the register file, registered from the stored register values
   typedef struct packed {
      logic [31:0] src_base;
      logic [13:0] src_row_bytes;
      logic [15:0] stride;
      step_type    step_col;
      step_type    step_row;
      logic [31:0] start;
   } cfg_derived_type;

   function automatic step_type smul(input coef_type k, input step_type v);
      step_type r;
      case (k)
         2'sd1:   r = v;
         -2'sd1:  r = -v;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ design/rfag_cfg.sv @@
// ----------------------------------------------------------------------------
// rfag_cfg
// Register file and derived geometry (strides, steps, start offset).
// ----------------------------------------------------------------------------
module rfag_cfg #(
   parameter int unsigned MAX_DIM = 2048
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rfag_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rfag_pkg::CSR_DATA_W-1:0]  csr_data,
   output rfag_pkg::cfg_derived_type        derived
);
   import rfag_pkg::*;

   logic [2:0]  orientation_ff, orientation_in;
   logic [2:0]  dest_depth_ff, dest_depth_in;
   logic [2:0]  src_depth_ff, src_depth_in;
   logic [11:0] guest_cols_ff, guest_cols_in;
   logic [11:0] guest_rows_ff, guest_rows_in;
   logic [15:0] pitch_ff, pitch_in;
   logic [15:0] line_ff, line_in;
   logic [31:0] base_ff, base_in;
   cfg_derived_type derived_ff, derived_in;

   logic [11:0] cols, rows, sw, sh;
   logic [15:0] sbytes;
   logic [2:0]  bpp;
   logic [31:0] sw_m1, sh_m1;
   logic [31:0] start_x, start_y;
   logic signed [2:0] sum_x, sum_y;
   rot_type     rot;
   step_type    line_s, bpp_s;

   assign csr_ready = 1'b1;

   always_comb begin
      orientation_in = orientation_ff;
      dest_depth_in  = dest_depth_ff;
      src_depth_in   = src_depth_ff;
      guest_cols_in  = guest_cols_ff;
      guest_rows_in  = guest_rows_ff;
      pitch_in       = pitch_ff;
      line_in        = line_ff;
      base_in        = base_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_ORIENTATION:     orientation_in = csr_data[2:0];
            REG_DEST_DEPTH_MODE: dest_depth_in  = csr_data[2:0];
            REG_SRC_DEPTH_MODE:  src_depth_in   = csr_data[2:0];
            REG_GUEST_COLS:      guest_cols_in  = csr_data[11:0];
            REG_GUEST_ROWS:      guest_rows_in  = csr_data[11:0];
            REG_SRC_ROW_PITCH:   pitch_in       = {csr_data[15:2], 2'b00};
            REG_DEST_LINE_BYTES: line_in        = csr_data[15:0];
            REG_SRC_BASE:        base_in        = {csr_data[31:2], 2'b00};
            default: ;
         endcase
      end
   end

   always_comb begin
      cols = (32'(guest_cols_ff) > 32'(MAX_DIM)) ? 12'(MAX_DIM) : guest_cols_ff;
      rows = (32'(guest_rows_ff) > 32'(MAX_DIM)) ? 12'(MAX_DIM) : guest_rows_ff;
      sw   = orientation_ff[0] ? rows : cols;
      sh   = orientation_ff[0] ? cols : rows;

      case (src_depth_ff)
         SRC_1BPP:              sbytes = {7'd0, cols[11:3]};
         SRC_2BPP:              sbytes = {6'd0, cols[11:2]};
         SRC_4BPP:              sbytes = {5'd0, cols[11:1]};
         SRC_8BPP:              sbytes = {4'd0, cols};
         SRC_15BPP, SRC_16BPP:  sbytes = {3'd0, cols, 1'b0};
         SRC_24BPP:             sbytes = {3'd0, cols, 1'b0} + {4'd0, cols};
         default:               sbytes = {2'd0, cols, 2'b00};
      endcase
      if (src_depth_ff != SRC_24BPP) begin
         sbytes[1:0] = 2'b00;
      end

      case (dest_depth_ff)
         DST_8BPP:              bpp = 3'd1;
         DST_15BPP, DST_16BPP:  bpp = 3'd2;
         DST_24BPP:             bpp = 3'd3;
         default:               bpp = 3'd4;
      endcase

      rot    = ROT_TAB[orientation_ff];
      sum_x  = 3'(rot.r0) + 3'(rot.r2);
      sum_y  = 3'(rot.r1) + 3'(rot.r3);
      sw_m1  = {20'd0, sw} - 32'd1;
      sh_m1  = {20'd0, sh} - 32'd1;
      start_x = (sum_x < 0) ? sw_m1 * {29'd0, bpp} : 32'd0;
      start_y = (sum_y < 0) ? sh_m1 * {16'd0, line_ff} : 32'd0;

      line_s = {2'b00, line_ff};
      bpp_s  = {15'd0, bpp};

      derived_in.src_base      = base_ff;
      derived_in.src_row_bytes = sbytes[13:0];
      derived_in.stride        = (pitch_ff != 16'd0) ? pitch_ff : sbytes;
      derived_in.step_col      = smul(rot.r1, line_s) + smul(rot.r0, bpp_s);
      derived_in.step_row      = smul(rot.r3, line_s) + smul(rot.r2, bpp_s);
      derived_in.start         = start_x + start_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         orientation_ff <= 3'd0;
         dest_depth_ff  <= 3'd4;
         src_depth_ff   <= 3'd7;
         guest_cols_ff  <= 12'd640;
         guest_rows_ff  <= 12'd480;
         pitch_ff       <= 16'd0;
         line_ff        <= 16'd2560;
         base_ff        <= 32'd0;
      end else begin
         orientation_ff <= orientation_in;
         dest_depth_ff  <= dest_depth_in;
         src_depth_ff   <= src_depth_in;
         guest_cols_ff  <= guest_cols_in;
         guest_rows_ff  <= guest_rows_in;
         pitch_ff       <= pitch_in;
         line_ff        <= line_in;
         base_ff        <= base_in;
      end
      derived_ff <= derived_in;
   end

   assign derived = derived_ff;

endmodule

@@ design/rotated_framebuffer_address_gen.sv @@
// ----------------------------------------------------------------------------
// rotated_framebuffer_address_gen
// Source row address and rotated destination byte offset per guest pixel.
//
//   channel  dir  ports                          word contents
//   req      in   req_tvalid/tready/tdata[23:0]  pix_row, pix_col
//   rsp      out  rsp_tvalid/tready/tdata[95:0]  row address, row bytes,
//                                                pixel offset, pixel step
//   csr      in   csr_valid/ready/index/data     register index, value
//
// One word per cycle sustained while rsp_tready stays high; each req word passes
// the input register, multiplier register and result register before rsp valid.
// Derived geometry is registered from the csr register values after a csr write.
// Reset restores register defaults and empties the pipeline.
// A stage holds while the stage after it is full and stalled; bubbles keep
// req_tready high while a result waits.
// ----------------------------------------------------------------------------
module rotated_framebuffer_address_gen #(
   parameter int unsigned MAX_DIM = 2048
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rfag_pkg::REQ_DATA_W-1:0]  req_tdata,   // pix_row[10:0], pix_col[21:11]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // src_row_address[31:0], src_row_bytes[45:32], dest_pixel_offset[77:46],
   // dest_pixel_step[94:78]
   output logic [rfag_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rfag_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rfag_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rfag_pkg::*;

   cfg_derived_type derived;

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;
   logic ready1, ready2, ready3;

   logic [10:0] row_ff, row_in;
   logic [10:0] col_ff, col_in;

   logic [26:0]        addr_prod_ff, addr_prod_in;
   logic signed [29:0] row_prod_ff, row_prod_in;
   logic signed [29:0] col_prod_ff, col_prod_in;

   logic [31:0] src_addr_ff, src_addr_in;
   logic [13:0] row_bytes_ff, row_bytes_in;
   logic [31:0] offset_ff, offset_in;
   logic [16:0] step_ff, step_in;

   rfag_cfg #(
      .MAX_DIM (MAX_DIM)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .derived   (derived)
   );

   assign ready3     = !out_valid_ff || rsp_tready;
   assign ready2     = !s2_valid_ff || ready3;
   assign ready1     = !s1_valid_ff || ready2;
   assign req_tready = ready1;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s2_valid_in  = s2_valid_ff;
      out_valid_in = out_valid_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      addr_prod_in = addr_prod_ff;
      row_prod_in  = row_prod_ff;
      col_prod_in  = col_prod_ff;
      src_addr_in  = src_addr_ff;
      row_bytes_in = row_bytes_ff;
      offset_in    = offset_ff;
      step_in      = step_ff;

      if (ready1) begin
         s1_valid_in = req_tvalid;
         row_in      = req_tdata[10:0];
         col_in      = req_tdata[21:11];
      end

      if (ready2) begin
         s2_valid_in  = s1_valid_ff;
         addr_prod_in = {16'd0, row_ff} * {11'd0, derived.stride};
         row_prod_in  = 30'($signed({1'b0, row_ff})) * 30'(derived.step_row);
         col_prod_in  = 30'($signed({1'b0, col_ff})) * 30'(derived.step_col);
      end

      if (ready3) begin
         out_valid_in = s2_valid_ff;
         src_addr_in  = derived.src_base + {5'd0, addr_prod_ff};
         row_bytes_in = derived.src_row_bytes;
         offset_in    = derived.start
                        + {{2{row_prod_ff[29]}}, row_prod_ff}
                        + {{2{col_prod_ff[29]}}, col_prod_ff};
         step_in      = derived.step_col[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
      row_ff       <= row_in;
      col_ff       <= col_in;
      addr_prod_ff <= addr_prod_in;
      row_prod_ff  <= row_prod_in;
      col_prod_ff  <= col_prod_in;
      src_addr_ff  <= src_addr_in;
      row_bytes_ff <= row_bytes_in;
      offset_ff    <= offset_in;
      step_ff      <= step_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, step_ff, offset_ff, row_bytes_ff, src_addr_ff};

endmodule
